// ===== rtl/atc_pkg.sv =====
// shared constants, types and codes of the audio tail crossfader
package atc_pkg;

    // sizes
    localparam int unsigned STORE_DEPTH  = 1048576;
    localparam int unsigned SAMPLE_WIDTH = 32;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned OVL_W        = 20;
    localparam int unsigned MS_W         = 32;
    localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);
    localparam int unsigned FILL_W       = ADDR_W + 1;
    localparam int unsigned FRAC_W       = 16;
    localparam int unsigned GAIN_W       = FRAC_W + 1;
    localparam int unsigned PROD_W       = DATA_W + GAIN_W + 1;
    localparam int unsigned REM_W        = MS_W + 2;

    // constants
    localparam logic [OVL_W-1:0]  OVL_RESET = OVL_W'(6000);
    localparam logic [OVL_W:0]    GUARD_MS  = (OVL_W + 1)'(2000);
    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << FRAC_W;

    // playback phase
    typedef enum logic [1:0] {
        PH_WAITING,
        PH_CHECKING,
        PH_PREPARING,
        PH_PROCESSING
    } phase_t;

    // sequencer state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_ACT,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_EMIT
    } state_t;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul;
        logic use_old;
        logic acc_load;
        logic acc_add;
    } mix_ctrl_t;

    // per-word phase decision
    typedef struct packed {
        phase_t phase;
        logic   storing;
        logic   req;
        logic   total_load;
        logic   gain_one;
        logic   div_start;
    } decision_t;

endpackage

// ===== rtl/atc_if.sv =====
// handshake channels of the audio tail crossfader
interface atc_in_if;
    import atc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     chunk_start;
    logic [MS_W-1:0]          track_length_ms;
    logic [MS_W-1:0]          elapsed_ms;
    logic                     next_accepted;

    modport source (output valid, sample, chunk_start, track_length_ms, elapsed_ms,
                    next_accepted, input ready);
    modport sink (input valid, sample, chunk_start, track_length_ms, elapsed_ms,
                  next_accepted, output ready);
endinterface

interface atc_out_if;
    import atc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample_out;
    logic                     next_track_request;

    modport source (output valid, sample_out, next_track_request, input ready);
    modport sink (input valid, sample_out, next_track_request, output ready);
endinterface

interface atc_cfg_if;
    import atc_pkg::*;
    logic             valid;
    logic             ready;
    logic [OVL_W-1:0] overlap_ms;

    modport source (output valid, overlap_ms, input ready);
    modport sink (input valid, overlap_ms, output ready);
endinterface

// ===== rtl/audio_tail_crossfader.sv =====
// top level of the audio tail crossfader: phase sequencer, tail fifo and output word
//
// Channels: samples (sink) takes one PCM word with chunk start, track length,
// elapsed time and next-track acceptance; results (source) gives the output
// sample and the next-track request flag; cfg (sink) writes overlap_ms and is
// always ready.
// A word is taken only while the sequencer is idle. A pass-through word is
// registered at the output from the emit state, after the decide and act
// states; a mixed word goes from act through mul1, mul2 and acc to emit; a word
// that is stored in the tail fifo gives no output and returns to idle from act.
// On the first word of a chunk in processing, the q16 gain is recomputed: by a
// serial divider, one quotient bit a cycle, in the div state after decide while
// the fifo fill is below its start total, else it is set to one. The single
// multiplier is used twice per mixed word, which sets the mix latency.
// Reset (rst_n low, asynchronous) returns the phase to waiting, empties the
// fifo and sets overlap_ms to 6000; the fifo ram itself is not cleared.
// When the receiver stalls, the result stays in the output register; the next
// word is still taken and worked through, then waits before its output until
// that result has been taken, and no further word is taken meanwhile.
module audio_tail_crossfader (
    input logic clk,
    input logic rst_n,
    atc_in_if.sink    samples,
    atc_out_if.source results,
    atc_cfg_if.sink   cfg
);
    import atc_pkg::*;

    localparam int unsigned SEXT_SH = DATA_W - SAMPLE_WIDTH;

    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;
    logic [OVL_W-1:0]         ovl_reg, ovl_next;
    logic [ADDR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [FILL_W-1:0]        total_reg, total_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic                     storing_reg, storing_next;
    logic                     req_reg, req_next;
    logic                     mix_sel_reg, mix_sel_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_sample_reg, out_sample_next;
    logic                     out_req_reg, out_req_next;

    logic signed [DATA_W-1:0] smp_reg;
    logic                     start_reg;
    logic [MS_W-1:0]          len_reg;
    logic [MS_W-1:0]          el_reg;
    logic                     nacc_reg;

    logic                     accept;
    logic                     emit;
    decision_t                dec;
    logic signed [REM_W-1:0]  remain;
    logic [OVL_W:0]           ov_guard;
    logic                     len_gt, rem_lt_guard, rem_lt_ov;
    logic [FILL_W:0]          wsum;
    logic [ADDR_W-1:0]        waddr;
    logic                     ram_we;
    logic [DATA_W-1:0]        ram_rdata;
    logic                     div_start, div_done;
    logic [FRAC_W-1:0]        div_q;
    mix_ctrl_t                mix_ctrl;
    logic signed [DATA_W-1:0] mix_result;
    logic signed [DATA_W-1:0] smp_ext;

    assign accept        = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign emit          = (state_reg == ST_EMIT) && (!out_valid_reg || results.ready);
    assign smp_ext       = $signed(samples.sample << SEXT_SH) >>> SEXT_SH;

    // time window compares
    always_comb
    begin
        remain       = $signed({2'b00, len_reg}) - $signed({2'b00, el_reg});
        ov_guard     = {1'b0, ovl_reg} + GUARD_MS;
        len_gt       = len_reg > MS_W'(ov_guard);
        rem_lt_guard = remain < $signed(REM_W'(ov_guard));
        rem_lt_ov    = remain < $signed(REM_W'(ovl_reg));
    end

    // phase decision for the held word
    always_comb
    begin
        dec            = '0;
        dec.phase      = phase_reg;
        dec.storing    = storing_reg;
        if (start_reg)
        begin
            dec.storing = 1'b0;
            unique case (phase_reg)
                PH_WAITING:
                begin
                    if (len_gt && rem_lt_guard)
                    begin
                        dec.req   = 1'b1;
                        dec.phase = PH_CHECKING;
                    end
                end
                PH_CHECKING:
                begin
                    if (nacc_reg)
                    begin
                        dec.phase = PH_PREPARING;
                    end
                end
                default:
                begin
                end
            endcase
            unique case (dec.phase)
                PH_PREPARING:
                begin
                    if (len_reg != '0 && rem_lt_ov)
                    begin
                        dec.storing = 1'b1;
                    end
                    else if (fill_reg != '0)
                    begin
                        dec.phase      = PH_PROCESSING;
                        dec.total_load = 1'b1;
                        dec.gain_one   = 1'b1;
                    end
                end
                PH_PROCESSING:
                begin
                    if (fill_reg == '0)
                    begin
                        dec.phase = PH_WAITING;
                    end
                    else if (total_reg == '0 || fill_reg >= total_reg)
                    begin
                        dec.gain_one = 1'b1;
                    end
                    else
                    begin
                        dec.div_start = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = dec.div_start ? ST_DIV : ST_ACT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                priority if (phase_reg == PH_PREPARING && storing_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (phase_reg == PH_PROCESSING && fill_reg != '0)
                begin
                    state_next = ST_MUL1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fifo write address, wrapped at the store depth
    always_comb
    begin
        wsum  = {2'b00, rd_ptr_reg} + {1'b0, fill_reg};
        waddr = (wsum >= (FILL_W + 1)'(STORE_DEPTH)) ?
                ADDR_W'(wsum - (FILL_W + 1)'(STORE_DEPTH)) : ADDR_W'(wsum);
    end

    // sequencer outputs and register updates
    always_comb
    begin
        phase_next      = phase_reg;
        ovl_next        = ovl_reg;
        rd_ptr_next     = rd_ptr_reg;
        fill_next       = fill_reg;
        total_next      = total_reg;
        gain_next       = gain_reg;
        storing_next    = storing_reg;
        req_next        = req_reg;
        mix_sel_next    = mix_sel_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_req_next    = out_req_reg;
        ram_we          = 1'b0;
        div_start       = 1'b0;
        mix_ctrl        = '0;

        if (cfg.valid && cfg.ready)
        begin
            ovl_next = cfg.overlap_ms;
        end
        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_DECIDE:
            begin
                phase_next   = dec.phase;
                storing_next = dec.storing;
                req_next     = dec.req;
                div_start    = dec.div_start;
                if (dec.total_load)
                begin
                    total_next = fill_reg;
                end
                if (dec.gain_one)
                begin
                    gain_next = GAIN_ONE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    gain_next = {1'b0, div_q};
                end
            end
            ST_ACT:
            begin
                mix_sel_next = (phase_reg == PH_PROCESSING) && (fill_reg != '0);
                if (phase_reg == PH_PREPARING && storing_reg &&
                    fill_reg < FILL_W'(STORE_DEPTH))
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            ST_MUL1:
            begin
                mix_ctrl.mul = 1'b1;
            end
            ST_MUL2:
            begin
                mix_ctrl.mul      = 1'b1;
                mix_ctrl.use_old  = 1'b1;
                mix_ctrl.acc_load = 1'b1;
                fill_next         = fill_reg - FILL_W'(1);
                rd_ptr_next       = (rd_ptr_reg == ADDR_W'(STORE_DEPTH - 1)) ?
                                    '0 : rd_ptr_reg + ADDR_W'(1);
            end
            ST_ACC:
            begin
                mix_ctrl.acc_add = 1'b1;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = mix_sel_reg ? mix_result : smp_reg;
                    out_req_next    = req_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WAITING;
            ovl_reg       <= OVL_RESET;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            gain_reg      <= '0;
            storing_reg   <= 1'b0;
            req_reg       <= 1'b0;
            mix_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ovl_reg       <= ovl_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            gain_reg      <= gain_next;
            storing_reg   <= storing_next;
            req_reg       <= req_next;
            mix_sel_reg   <= mix_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word and output payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg   <= smp_ext;
            start_reg <= samples.chunk_start;
            len_reg   <= samples.track_length_ms;
            el_reg    <= samples.elapsed_ms;
            nacc_reg  <= samples.next_accepted;
        end
        out_sample_reg <= out_sample_next;
        out_req_reg    <= out_req_next;
    end

    // tail fifo storage, read port follows the read pointer
    atc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (smp_reg),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // fade gain divider
    atc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (fill_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // crossfade multiply-accumulate
    atc_mix u_mix (
        .clk    (clk),
        .ctrl   (mix_ctrl),
        .cur    (smp_reg),
        .old    ($signed(ram_rdata)),
        .gain   (gain_reg),
        .result (mix_result)
    );

    assign results.valid              = out_valid_reg;
    assign results.sample_out         = out_sample_reg;
    assign results.next_track_request = out_req_reg;

endmodule

// ===== rtl/atc_ram.sv =====
// generic single-write, single-read ram with registered read data
module atc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/atc_div.sv =====
// iterative restoring divider for the q16 fade gain, one quotient bit a cycle
module atc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [atc_pkg::FILL_W-1:0] dividend,
    input  logic [atc_pkg::FILL_W-1:0] divisor,
    output logic                      done,
    output logic [atc_pkg::FRAC_W-1:0] quotient
);
    import atc_pkg::*;

    localparam int unsigned CNT_W = $clog2(FRAC_W + 1);

    logic [FILL_W-1:0] rem_reg, rem_next;
    logic [FILL_W-1:0] dvs_reg, dvs_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [FILL_W:0]   shifted;
    logic              fits;

    // one shift-compare-subtract step
    always_comb
    begin
        shifted  = {rem_reg, 1'b0};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(FRAC_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? FILL_W'(shifted - {1'b0, dvs_reg}) : FILL_W'(shifted);
            quo_next = {quo_reg[FRAC_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/atc_mix.sv =====
// shared multiply-accumulate unit for the crossfade, truncating toward zero
module atc_mix (
    input  logic                             clk,
    input  atc_pkg::mix_ctrl_t               ctrl,
    input  logic signed [atc_pkg::DATA_W-1:0] cur,
    input  logic signed [atc_pkg::DATA_W-1:0] old,
    input  logic [atc_pkg::GAIN_W-1:0]       gain,
    output logic signed [atc_pkg::DATA_W-1:0] result
);
    import atc_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << FRAC_W) - 64'd1);

    logic signed [DATA_W-1:0] opnd;
    logic [GAIN_W-1:0]        wt;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic signed [PROD_W-1:0] acc_next, acc_reg;
    logic signed [PROD_W-1:0] biased, shifted;

    // operand select and product
    always_comb
    begin
        opnd      = ctrl.use_old ? old : cur;
        wt        = ctrl.use_old ? gain : GAIN_ONE - gain;
        prod_next = opnd * $signed({1'b0, wt});
    end

    // accumulator update
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_load)
        begin
            acc_next = prod_reg;
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + prod_reg;
        end
    end

    // product and accumulator registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // divide by 2^16 toward zero
    always_comb
    begin
        biased  = acc_reg[PROD_W-1] ? acc_reg + ROUND_BIAS : acc_reg;
        shifted = biased >>> FRAC_W;
        result  = shifted[DATA_W-1:0];
    end

endmodule
